>>> src/ccde_pkg.sv
// shared types, codes and helpers of the calendar clock
package ccde_pkg;

  typedef enum logic [1:0] {
    FUNC_TICK = 2'd0,
    FUNC_INC  = 2'd1,
    FUNC_DEC  = 2'd2
  } ccde_func_t;

  typedef enum logic [3:0] {
    DIG_HOUR_TENS   = 4'd0,
    DIG_HOUR_UNITS  = 4'd1,
    DIG_MIN_TENS    = 4'd2,
    DIG_MIN_UNITS   = 4'd3,
    DIG_SEC_TENS    = 4'd4,
    DIG_SEC_UNITS   = 4'd5,
    DIG_DAY_TENS    = 4'd6,
    DIG_DAY_UNITS   = 4'd7,
    DIG_MON_TENS    = 4'd8,
    DIG_MON_UNITS   = 4'd9,
    DIG_YEAR_THOU   = 4'd10,
    DIG_YEAR_HUND   = 4'd11,
    DIG_YEAR_TENS   = 4'd12,
    DIG_YEAR_UNITS  = 4'd13
  } ccde_digit_t;

  typedef struct packed {
    logic [1:0] func;
    logic [3:0] digit;
  } ccde_in_t;

  typedef struct packed {
    logic signed [15:0] year;
    logic signed [7:0]  month;
    logic signed [7:0]  day;
    logic signed [7:0]  hour;
    logic signed [7:0]  minute;
    logic signed [7:0]  second;
  } ccde_out_t;

  localparam ccde_out_t TIME_RESET = '{
    year: 16'sd1, month: 8'sd1, day: 8'sd1, hour: 8'sd0, minute: 8'sd0, second: 8'sd0
  };

  localparam logic signed [7:0] SEC_MAX   = 8'sd59;
  localparam logic signed [7:0] MIN_MAX   = 8'sd59;
  localparam logic signed [7:0] HOUR_MAX  = 8'sd23;
  localparam logic signed [7:0] MONTH_MAX = 8'sd12;
  localparam logic signed [7:0] FEB_SHORT = 8'sd28;
  localparam logic signed [7:0] FEB_LONG  = 8'sd29;

  localparam logic signed [7:0] MONTH_DAYS [12] = '{
    8'sd31, 8'sd28, 8'sd31, 8'sd30, 8'sd31, 8'sd30,
    8'sd31, 8'sd31, 8'sd30, 8'sd31, 8'sd30, 8'sd31
  };

  // divisibility by 25 through the modular inverse of 25 mod 2^16
  localparam logic [15:0] LEAP_INV25   = 16'd23593;
  localparam logic [15:0] LEAP_Q25_MAX = 16'd2621;

  function automatic logic signed [7:0] sat8(input logic signed [9:0] v);
    logic signed [7:0] r;
    if (v > 10'sd127) begin
      r = 8'sd127;
    end else if (v < -10'sd128) begin
      r = -8'sd128;
    end else begin
      r = 8'(v);
    end
    return r;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
    logic signed [15:0] r;
    if (v > 18'sd32767) begin
      r = 16'sd32767;
    end else if (v < -18'sd32768) begin
      r = -16'sd32768;
    end else begin
      r = 16'(v);
    end
    return r;
  endfunction

endpackage

>>> src/calendar_clock_with_digit_edit.sv
// top level of the calendar clock with digit editing
//
// input channel: in_valid/in_stall carry one ccde_in_t per transfer, a tick
// (one second forward with carry and borrow) or an increment or decrement of
// one decimal digit of hour, minute, second, day, month or year.
// result channel: out_valid/out_stall carry one ccde_out_t per input item,
// the full date and time after that item.
// an accepted item is held in the input register; when it moves out, the date
// and time register is updated and the result is presented from then on,
// so out_valid rises together with that update.
// throughput is one item per cycle while out_stall is low; the carry chain of a
// tick and the leap check on a year rollover are both combinational.
// reset sets 0001-01-01 00:00:00 with a 28-day February and empties both
// registers. while out_stall holds a result, the input register still takes
// one more item; after that in_stall follows out_stall.
module calendar_clock_with_digit_edit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  ccde_pkg::ccde_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output ccde_pkg::ccde_out_t out_data
);

  ccde_pkg::ccde_in_t  in_r;
  logic                in_vld_r;
  logic                in_vld_nxt;
  ccde_pkg::ccde_out_t time_r;
  ccde_pkg::ccde_out_t time_nxt;
  logic                feb_r;
  logic                feb_nxt;
  logic                out_vld_r;
  logic                out_vld_nxt;
  logic                move;
  logic                in_xfer;

  ccde_pkg::ccde_out_t tick_time;
  ccde_pkg::ccde_out_t edit_time;
  logic                year_roll;
  logic                leap;

  assign move     = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !move;
  assign in_xfer  = in_valid && !in_stall;

  ccde_tick u_tick (
    .cur       (time_r),
    .feb_long  (feb_r),
    .nxt       (tick_time),
    .year_roll (year_roll)
  );

  ccde_leap u_leap (
    .year (tick_time.year),
    .leap (leap)
  );

  ccde_edit u_edit (
    .cur   (time_r),
    .dec   (in_r.func == ccde_pkg::FUNC_DEC),
    .digit (in_r.digit),
    .nxt   (edit_time)
  );

  always_comb begin
    time_nxt    = time_r;
    feb_nxt     = feb_r;
    in_vld_nxt  = in_vld_r;
    out_vld_nxt = out_vld_r;
    if (move) begin
      unique case (in_r.func)
        ccde_pkg::FUNC_TICK: begin
          time_nxt = tick_time;
          feb_nxt  = year_roll ? leap : feb_r;
        end
        ccde_pkg::FUNC_INC,
        ccde_pkg::FUNC_DEC: time_nxt = edit_time;
        default:            time_nxt = time_r;
      endcase
    end
    if (in_xfer) begin
      in_vld_nxt = 1'b1;
    end else if (move) begin
      in_vld_nxt = 1'b0;
    end
    if (move) begin
      out_vld_nxt = 1'b1;
    end else if (!out_stall) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      time_r    <= ccde_pkg::TIME_RESET;
      feb_r     <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
      time_r    <= time_nxt;
      feb_r     <= feb_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      in_r <= in_data;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = time_r;

  // every transfer out of the input register produces a result
  a_move_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    move |=> out_vld_r)
    else $error("result missing after input register transfer");

  // the input side is held back only while an item waits
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> in_vld_r)
    else $error("input stalled with empty input register");

  // a result appears only from a transfer out of the input register
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && out_vld_r && !$past(out_vld_r)) |-> $past(move))
    else $error("result valid without a source item");

  // the february flag changes only on a tick transfer
  a_feb_tick: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (feb_r != $past(feb_r))) |->
      ($past(move) && ($past(in_r.func) == ccde_pkg::FUNC_TICK)))
    else $error("february flag changed outside a tick");

  // a tick always leaves the second normalized
  a_tick_second: assert property (@(posedge clk) disable iff (!rst_n)
    (move && (in_r.func == ccde_pkg::FUNC_TICK)) |=>
      ((time_r.second >= 8'sd0) && (time_r.second <= ccde_pkg::SEC_MAX)))
    else $error("second out of range after tick");

endmodule

>>> src/ccde_leap.sv
// leap year decision for a signed year value
module ccde_leap (
  input  logic signed [15:0] year,
  output logic               leap
);

  logic [15:0] mag;
  logic [15:0] prod;
  logic        div4;
  logic        div16;
  logic        div25;

  assign mag   = year[15] ? 16'(~year + 16'd1) : 16'(year);
  assign prod  = 16'(mag * ccde_pkg::LEAP_INV25);
  assign div4  = (year[1:0] == 2'd0);
  assign div16 = (year[3:0] == 4'd0);
  assign div25 = (prod <= ccde_pkg::LEAP_Q25_MAX);

  // divisible by 4, and by 400 or not by 100
  assign leap = div4 && (div16 || !div25);

endmodule

>>> src/ccde_tick.sv
// one-second tick with a single ordered carry and borrow pass
module ccde_tick (
  input  ccde_pkg::ccde_out_t cur,
  input  logic                feb_long,
  output ccde_pkg::ccde_out_t nxt,
  output logic                year_roll
);

  function automatic logic signed [7:0] mlen(input logic signed [7:0] m, input logic fl);
    logic [3:0]        c;
    logic signed [7:0] r;
    if (m < 8'sd1) begin
      c = 4'd1;
    end else if (m > ccde_pkg::MONTH_MAX) begin
      c = 4'd12;
    end else begin
      c = 4'(m);
    end
    if (c == 4'd2) begin
      r = fl ? ccde_pkg::FEB_LONG : ccde_pkg::FEB_SHORT;
    end else begin
      r = ccde_pkg::MONTH_DAYS[c - 4'd1];
    end
    return r;
  endfunction

  ccde_pkg::ccde_out_t t;
  logic                roll;

  always_comb begin
    t    = cur;
    roll = 1'b0;
    t.second = ccde_pkg::sat8(10'(t.second) + 10'sd1);
    if (t.second > ccde_pkg::SEC_MAX) begin
      t.minute = ccde_pkg::sat8(10'(t.minute) + 10'sd1);
      t.second = 8'sd0;
    end
    if (t.second < 8'sd0) begin
      t.minute = ccde_pkg::sat8(10'(t.minute) - 10'sd1);
      t.second = ccde_pkg::SEC_MAX;
    end
    if (t.minute > ccde_pkg::MIN_MAX) begin
      t.hour   = ccde_pkg::sat8(10'(t.hour) + 10'sd1);
      t.minute = 8'sd0;
    end
    if (t.minute < 8'sd0) begin
      t.hour   = ccde_pkg::sat8(10'(t.hour) - 10'sd1);
      t.minute = ccde_pkg::MIN_MAX;
    end
    if (t.hour > ccde_pkg::HOUR_MAX) begin
      t.day  = ccde_pkg::sat8(10'(t.day) + 10'sd1);
      t.hour = 8'sd0;
    end
    if (t.hour < 8'sd0) begin
      t.day  = ccde_pkg::sat8(10'(t.day) - 10'sd1);
      t.hour = ccde_pkg::HOUR_MAX;
    end
    if (t.day > mlen(t.month, feb_long)) begin
      t.month = ccde_pkg::sat8(10'(t.month) + 10'sd1);
      t.day   = 8'sd1;
    end
    if (t.day < 8'sd1) begin
      t.month = ccde_pkg::sat8(10'(t.month) - 10'sd1);
      t.day   = mlen(t.month, feb_long);
    end
    if (t.month > ccde_pkg::MONTH_MAX) begin
      t.year  = ccde_pkg::sat16(18'(t.year) + 18'sd1);
      t.month = 8'sd1;
      roll    = 1'b1;
    end
    if (t.month < 8'sd1) begin
      t.year  = ccde_pkg::sat16(18'(t.year) - 18'sd1);
      t.month = ccde_pkg::MONTH_MAX;
      roll    = 1'b1;
    end
  end

  assign nxt       = t;
  assign year_roll = roll;

endmodule

>>> src/ccde_edit.sv
// digit edit: add or subtract one decimal step at a selected position
module ccde_edit (
  input  ccde_pkg::ccde_out_t cur,
  input  logic                dec,
  input  logic [3:0]          digit,
  output ccde_pkg::ccde_out_t nxt
);

  logic signed [9:0]  d1;
  logic signed [9:0]  d10;
  logic signed [17:0] y1;
  logic signed [17:0] y10;
  logic signed [17:0] y100;
  logic signed [17:0] y1000;
  ccde_pkg::ccde_out_t t;

  assign d1    = dec ? -10'sd1    : 10'sd1;
  assign d10   = dec ? -10'sd10   : 10'sd10;
  assign y1    = dec ? -18'sd1    : 18'sd1;
  assign y10   = dec ? -18'sd10   : 18'sd10;
  assign y100  = dec ? -18'sd100  : 18'sd100;
  assign y1000 = dec ? -18'sd1000 : 18'sd1000;

  always_comb begin
    t = cur;
    unique case (digit)
      ccde_pkg::DIG_HOUR_TENS:  t.hour   = ccde_pkg::sat8(10'(cur.hour) + d10);
      ccde_pkg::DIG_HOUR_UNITS: t.hour   = ccde_pkg::sat8(10'(cur.hour) + d1);
      ccde_pkg::DIG_MIN_TENS:   t.minute = ccde_pkg::sat8(10'(cur.minute) + d10);
      ccde_pkg::DIG_MIN_UNITS:  t.minute = ccde_pkg::sat8(10'(cur.minute) + d1);
      ccde_pkg::DIG_SEC_TENS:   t.second = ccde_pkg::sat8(10'(cur.second) + d10);
      ccde_pkg::DIG_SEC_UNITS:  t.second = ccde_pkg::sat8(10'(cur.second) + d1);
      ccde_pkg::DIG_DAY_TENS:   t.day    = ccde_pkg::sat8(10'(cur.day) + d10);
      ccde_pkg::DIG_DAY_UNITS:  t.day    = ccde_pkg::sat8(10'(cur.day) + d1);
      ccde_pkg::DIG_MON_TENS:   t.month  = ccde_pkg::sat8(10'(cur.month) + d10);
      ccde_pkg::DIG_MON_UNITS:  t.month  = ccde_pkg::sat8(10'(cur.month) + d1);
      ccde_pkg::DIG_YEAR_THOU:  t.year   = ccde_pkg::sat16(18'(cur.year) + y1000);
      ccde_pkg::DIG_YEAR_HUND:  t.year   = ccde_pkg::sat16(18'(cur.year) + y100);
      ccde_pkg::DIG_YEAR_TENS:  t.year   = ccde_pkg::sat16(18'(cur.year) + y10);
      ccde_pkg::DIG_YEAR_UNITS: t.year   = ccde_pkg::sat16(18'(cur.year) + y1);
      default:                  t        = cur;
    endcase
  end

  assign nxt = t;

endmodule
